FILE: hw/rtl/skfo_pkg.sv
// Shared types, constants and the microcode program of the keystream frame overlay.
// No dependencies; every other file of the block imports this package.
package skfo_pkg;

   localparam int KS_MAX_BITS_DEF = 882;
   localparam int FRAME_W         = 49;
   localparam int LEN_W           = 10;
   localparam int BIDX_W          = 7;
   localparam int BYTE_W          = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 10;
   localparam int TAIL_LO         = 24;
   localparam int TAIL_HI         = 44;
   localparam int CNT_W           = $clog2(FRAME_W + 1);
   localparam int STEP_W          = 4;

   localparam logic [LEN_W-1:0] KS_LEN_RESET = LEN_W'(882);
   localparam logic [55:0]      SILENCE_WORD = 56'hF801A99F8CE080;

   // Frame bit i of the silence pattern is bit 55-i of the packed word.
   function automatic logic [FRAME_W-1:0] silence_frame();
      logic [FRAME_W-1:0] f;
      for (int i = 0; i < FRAME_W; i++) begin
         f[i] = SILENCE_WORD[55 - i];
      end
      return f;
   endfunction

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE    = 3'd0,
      CSR_KS_LENGTH = 3'd1,
      CSR_ALIGN     = 3'd2,
      CSR_OFFSET    = 3'd3,
      CSR_STEP      = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_IDLE,
      OP_REM_INIT,
      OP_REM_STEP,
      OP_SUMS,
      OP_WALK,
      OP_FINISH,
      OP_EMIT,
      OP_WRITE
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_IS_LOAD,
      C_BYPASS,
      C_REM_MORE,
      C_SKIP,
      C_WALK_MORE,
      C_OUT_BUSY
   } cond_type;

   localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
   localparam logic [STEP_W-1:0] ST_CHECK    = 4'd2;
   localparam logic [STEP_W-1:0] ST_REM      = 4'd3;
   localparam logic [STEP_W-1:0] ST_SUMS     = 4'd4;
   localparam logic [STEP_W-1:0] ST_WALK     = 4'd5;
   localparam logic [STEP_W-1:0] ST_FINISH   = 4'd6;
   localparam logic [STEP_W-1:0] ST_EMIT     = 4'd7;
   localparam logic [STEP_W-1:0] ST_RETURN   = 4'd8;
   localparam logic [STEP_W-1:0] ST_WRITE    = 4'd9;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              cnt_clr;
      logic              cnt_inc;
   } ucode_word_type;

   typedef struct packed {
      logic accept;
      logic is_load;
      logic bypass;
      logic skip;
      logic out_busy;
   } seq_status_type;

   // The program: a taken condition jumps to target, otherwise the next step follows.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] s);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, cnt_clr: 1'b0, cnt_inc: 1'b0};
      case (s)
         ST_IDLE:     w = '{OP_IDLE,     C_NO_ACCEPT, ST_IDLE,  1'b0, 1'b0};
         ST_DISPATCH: w = '{OP_REM_INIT, C_IS_LOAD,   ST_WRITE, 1'b1, 1'b0};
         ST_CHECK:    w = '{OP_NOP,      C_BYPASS,    ST_EMIT,  1'b0, 1'b0};
         ST_REM:      w = '{OP_REM_STEP, C_REM_MORE,  ST_REM,   1'b0, 1'b1};
         ST_SUMS:     w = '{OP_SUMS,     C_SKIP,      ST_EMIT,  1'b1, 1'b0};
         ST_WALK:     w = '{OP_WALK,     C_WALK_MORE, ST_WALK,  1'b0, 1'b1};
         ST_FINISH:   w = '{OP_FINISH,   C_NEVER,     ST_IDLE,  1'b0, 1'b0};
         ST_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY,  ST_EMIT,  1'b0, 1'b0};
         ST_RETURN:   w = '{OP_NOP,      C_ALWAYS,    ST_IDLE,  1'b0, 1'b0};
         ST_WRITE:    w = '{OP_WRITE,    C_ALWAYS,    ST_IDLE,  1'b0, 1'b0};
         default:     w = '{OP_NOP,      C_ALWAYS,    ST_IDLE,  1'b0, 1'b0};
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/skfo_ifs.sv
// Valid/ready channel interfaces of the keystream frame overlay: request, response, CSR.
// Depends on skfo_pkg for the field widths.
interface skfo_req_if import skfo_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic                slot;
   logic [BIDX_W-1:0]   byte_index;
   logic [BYTE_W-1:0]   byte_value;
   logic [FRAME_W-1:0]  frame_bits;

   modport source (output valid, action, slot, byte_index, byte_value, frame_bits,
                   input ready);
   modport sink   (input valid, action, slot, byte_index, byte_value, frame_bits,
                   output ready);
endinterface

interface skfo_rsp_if import skfo_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  frame_out;
   logic                applied;

   modport source (output valid, frame_out, applied, input ready);
   modport sink   (input valid, frame_out, applied, output ready);
endinterface

interface skfo_csr_if import skfo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/skfo_ks_mem.sv
// Keystream store: one byte per entry, one write port, one registered read port.
// Depends on skfo_pkg for the byte width.
module skfo_ks_mem import skfo_pkg::*; #(
   parameter int KS_MAX_BITS = KS_MAX_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [$clog2((KS_MAX_BITS+7)/8)-1:0]    wr_addr,
   input  logic [BYTE_W-1:0]                       wr_data,
   input  logic [$clog2((KS_MAX_BITS+7)/8)-1:0]    rd_addr,
   output logic [BYTE_W-1:0]                       rd_data
);

   localparam int KsBytes = (KS_MAX_BITS + 7) / 8;

   logic [BYTE_W-1:0] mem [KsBytes];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/skfo_mod_unit.sv
// Two-lane restoring remainder unit, one dividend bit per step in each lane.
// Depends on skfo_pkg for the length width.
module skfo_mod_unit import skfo_pkg::*; (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [LEN_W-1:0]            modulus,
   input  logic [1:0][LEN_W-1:0]       dividend,
   output logic [1:0][LEN_W-1:0]       remainder
);

   logic [1:0][LEN_W-1:0] quo_ff, quo_in;
   logic [1:0][LEN_W-1:0] rem_ff, rem_in;

   always_comb begin
      logic [LEN_W:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int l = 0; l < 2; l++) begin
         trial = {rem_ff[l], quo_ff[l][LEN_W-1]};
         if (start) begin
            quo_in[l] = dividend[l];
            rem_in[l] = '0;
         end else if (step) begin
            quo_in[l] = {quo_ff[l][LEN_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus}) begin
               rem_in[l] = LEN_W'(trial - {1'b0, modulus});
            end else begin
               rem_in[l] = trial[LEN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/skfo_seq.sv
// Microcode sequencer: step counter, loop counter and jump logic over the program ROM.
// Depends on skfo_pkg for the control word, status bundle and program.
module skfo_seq import skfo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ucode_word_type cw
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ucode_word_type    word;
   logic              taken;

   always_comb begin
      word = ucode_rom(step_ff);
      case (word.cond)
         C_NEVER:     taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_NO_ACCEPT: taken = !status.accept;
         C_IS_LOAD:   taken = status.is_load;
         C_BYPASS:    taken = status.bypass;
         C_REM_MORE:  taken = (cnt_ff != CNT_W'(LEN_W - 1));
         C_SKIP:      taken = status.skip;
         C_WALK_MORE: taken = (cnt_ff != CNT_W'(FRAME_W - 1));
         C_OUT_BUSY:  taken = status.out_busy;
         default:     taken = 1'b0;
      endcase
      step_in = taken ? word.target : STEP_W'(step_ff + 1'b1);
      if (word.cnt_clr) begin
         cnt_in = '0;
      end else if (word.cnt_inc) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign cw = word;

endmodule

FILE: hw/rtl/static_keystream_frame_overlay_unit.sv
// Static keystream overlay for 49-bit voice frames, top level and datapath.
// Depends on skfo_pkg, skfo_ifs, skfo_ks_mem, skfo_mod_unit and skfo_seq.
//
// The request channel carries two kinds of words. A load word (action 0) writes one
// keystream byte; its most significant bit becomes keystream bit 8n. A frame word
// (action 1) is XORed with 49 keystream bits taken from the slot's current base,
// wrapping at the keystream length, and returns exactly one response word holding
// the frame and an applied flag. Load words return nothing.
// The CSR channel is always ready; any write to a listed register clears both slot
// positions. Registers must be written only while the block is idle; the block
// itself does not enforce this. A load word is dispatched and then written. A frame
// is dispatched and checked for bypass; if not bypassed, the remainder unit reduces
// offset and step modulo the length, the position sums are formed and, unless it is
// a silence frame or has an empty tail, a walk through the single read port of the
// keystream store gathers its 49 bits, then a finish step. Every frame ends in emit.
// The result sits in an output register, so the next request is accepted while it
// waits; only a second frame result stalls until the receiver takes the first.
// Synchronous reset clears positions, registers and the response valid. The
// keystream store is not cleared and must be loaded before frames use it.
module static_keystream_frame_overlay_unit import skfo_pkg::*; #(
   parameter int KS_MAX_BITS = KS_MAX_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   skfo_req_if.sink      req_ch,
   skfo_rsp_if.source    rsp_ch,
   skfo_csr_if.sink      csr_ch
);

   localparam int KsBytes = (KS_MAX_BITS + 7) / 8;
   localparam int AddrW   = $clog2(KsBytes);
   localparam logic [FRAME_W-1:0] SilenceFrame = silence_frame();

   // Configuration registers.
   logic             enable_ff;
   logic [LEN_W-1:0] ks_len_ff;
   logic             align_ff;
   logic [LEN_W-1:0] offset_ff;
   logic [LEN_W-1:0] fstep_ff;

   // Per-slot positions; they always stay below the length in use.
   logic [1:0][LEN_W-1:0] pos_ff;

   // Latched request word.
   logic               act_ff;
   logic               slot_ff;
   logic [BIDX_W-1:0]  bidx_ff;
   logic [BYTE_W-1:0]  bval_ff;
   logic [FRAME_W-1:0] frame_ff;

   // Walk state: current keystream index, read-return tracking and gathered bits.
   logic [LEN_W-1:0]   idx_ff;
   logic [2:0]         sel_ff;
   logic               rd_pend_ff;
   logic [FRAME_W-1:0] ks_ff;
   logic               applied_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_applied_ff;

   ucode_word_type        cw;
   seq_status_type        status;
   logic [LEN_W-1:0]      len_use;
   logic [1:0][LEN_W-1:0] div_in;
   logic [1:0][LEN_W-1:0] rem;
   logic [LEN_W-1:0]      pos_sel;
   logic [LEN_W-1:0]      base_nx;
   logic [LEN_W-1:0]      pos_nx;
   logic [LEN_W-1:0]      idx_inc;
   logic [LEN_W-1:0]      idx_nx;
   logic [BYTE_W-1:0]     rd_byte;
   logic                  accept;
   logic                  emit_go;
   logic                  mem_wr_en;

   // Sum of two values below m, brought back below m with one subtract.
   function automatic logic [LEN_W-1:0] add_mod(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b,
                                                input logic [LEN_W-1:0] m);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[LEN_W-1:0];
   endfunction

   // A programmed length beyond the store is clamped to the store size.
   assign len_use = ({1'b0, ks_len_ff} > (LEN_W + 1)'(KS_MAX_BITS)) ?
                    LEN_W'(KS_MAX_BITS) : ks_len_ff;

   assign accept = req_ch.valid && req_ch.ready;
   assign emit_go = (cw.op == OP_EMIT) && !status.out_busy;

   assign status.accept   = accept;
   assign status.is_load  = !act_ff;
   assign status.bypass   = !enable_ff || (len_use == '0);
   assign status.skip     = (frame_ff == SilenceFrame) || (frame_ff[TAIL_HI-1:TAIL_LO] == '0);
   assign status.out_busy = rsp_valid_ff && !rsp_ch.ready;

   assign req_ch.ready     = (cw.op == OP_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.frame_out = rsp_frame_ff;
   assign rsp_ch.applied   = rsp_applied_ff;

   // Lane 0 reduces the base offset, lane 1 the per-frame advance.
   assign div_in[0] = align_ff ? offset_ff : '0;
   assign div_in[1] = align_ff ? fstep_ff : LEN_W'(FRAME_W);

   assign pos_sel = pos_ff[slot_ff];
   assign base_nx = add_mod(rem[0], pos_sel, len_use);
   assign pos_nx  = add_mod(pos_sel, rem[1], len_use);
   assign idx_inc = idx_ff + LEN_W'(1);
   assign idx_nx  = (idx_inc == len_use) ? '0 : idx_inc;

   // Bytes past the end of the store are dropped.
   assign mem_wr_en = (cw.op == OP_WRITE) && (32'(bidx_ff) < KsBytes);

   skfo_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   skfo_mod_unit u_mod (
      .clock     (clock),
      .start     (cw.op == OP_REM_INIT),
      .step      (cw.op == OP_REM_STEP),
      .modulus   (len_use),
      .dividend  (div_in),
      .remainder (rem)
   );

   skfo_ks_mem #(
      .KS_MAX_BITS (KS_MAX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (bidx_ff[AddrW-1:0]),
      .wr_data (bval_ff),
      .rd_addr (idx_ff[AddrW+2:3]),
      .rd_data (rd_byte)
   );

   // Control state: configuration, positions, flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         ks_len_ff    <= KS_LEN_RESET;
         align_ff     <= 1'b0;
         offset_ff    <= '0;
         fstep_ff     <= '0;
         pos_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         applied_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (cw.op == OP_WALK);

         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end

         if (cw.op == OP_REM_INIT) begin
            applied_ff <= 1'b0;
         end
         if (cw.op == OP_FINISH) begin
            applied_ff <= 1'b1;
         end

         // The position moves even for silence frames, but not when bypassed.
         if (cw.op == OP_SUMS) begin
            pos_ff[slot_ff] <= pos_nx;
         end

         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_ENABLE: begin
                  enable_ff <= csr_ch.data[0];
                  pos_ff    <= '0;
               end
               CSR_KS_LENGTH: begin
                  ks_len_ff <= csr_ch.data;
                  pos_ff    <= '0;
               end
               CSR_ALIGN: begin
                  align_ff <= csr_ch.data[0];
                  pos_ff   <= '0;
               end
               CSR_OFFSET: begin
                  offset_ff <= csr_ch.data;
                  pos_ff    <= '0;
               end
               CSR_STEP: begin
                  fstep_ff <= csr_ch.data;
                  pos_ff   <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload: request latch, keystream walk and the output word.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_ch.action;
         slot_ff  <= req_ch.slot;
         bidx_ff  <= req_ch.byte_index;
         bval_ff  <= req_ch.byte_value;
         frame_ff <= req_ch.frame_bits;
      end

      // Read data comes back in the cycle after the address; bits enter from the top
      // so that after 49 of them the first one sits at frame bit 0.
      if (rd_pend_ff) begin
         ks_ff <= {rd_byte[~sel_ff], ks_ff[FRAME_W-1:1]};
      end

      if (cw.op == OP_SUMS) begin
         idx_ff <= base_nx;
      end else if (cw.op == OP_WALK) begin
         idx_ff <= idx_nx;
         sel_ff <= idx_ff[2:0];
      end

      if (emit_go) begin
         rsp_frame_ff   <= frame_ff ^ (applied_ff ? ks_ff : '0);
         rsp_applied_ff <= applied_ff;
      end
   end

endmodule

FILE: test/skfo_overlay_checker.sv
// Checker for the keystream frame overlay: watches the request, response and CSR channels.
// It predicts each frame result and compares it with the response words in order.
// Depends on skfo_pkg and the channel interfaces in skfo_ifs.
module skfo_overlay_checker import skfo_pkg::*; #(
   parameter int KS_BITS = KS_MAX_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   skfo_req_if   req_mon,
   skfo_rsp_if   rsp_mon,
   skfo_csr_if   csr_mon,
   output int    pending_frames,
   output int    mismatch_count
);

   typedef struct packed {
      logic [FRAME_W-1:0] frame_out;
      logic               applied;
   } overlay_result_type;

   logic                  ks_bits [KS_BITS];
   int                    slot_pos [2];
   logic                  cfg_enable;
   logic [LEN_W-1:0]      cfg_length;
   logic                  cfg_align;
   logic [LEN_W-1:0]      cfg_offset;
   logic [LEN_W-1:0]      cfg_step;
   overlay_result_type    expected_frames [$];
   int                    err_total = 0;

   // Works out one frame result and moves the slot position the way the block does.
   task automatic overlay_frame(input logic slot, input logic [FRAME_W-1:0] frame,
                                output overlay_result_type res);
      int                 len;
      int                 pos;
      int                 base;
      int                 adv;
      logic [FRAME_W-1:0] quiet;
      logic [FRAME_W-1:0] ks_word;
      res.frame_out = frame;
      res.applied   = 1'b0;
      len = (int'(cfg_length) > KS_BITS) ? KS_BITS : int'(cfg_length);
      if (!cfg_enable || len == 0) return;
      pos = slot_pos[slot] % len;
      if (cfg_align) begin
         base = ((int'(cfg_offset) % len) + pos) % len;
         adv  = int'(cfg_step) % len;
      end else begin
         base = pos;
         adv  = FRAME_W % len;
      end
      slot_pos[slot] = (pos + adv) % len;
      for (int i = 0; i < FRAME_W; i++) begin
         quiet[i] = SILENCE_WORD[55 - i];
      end
      // Silence frames and frames with an empty tail still consume keystream positions.
      if (frame == quiet || frame[TAIL_HI-1:TAIL_LO] == '0) return;
      for (int i = 0; i < FRAME_W; i++) begin
         ks_word[i] = ks_bits[(base + i) % len];
      end
      res.frame_out = frame ^ ks_word;
      res.applied   = 1'b1;
   endtask

   always @(posedge clock) begin
      overlay_result_type want;
      int                 bit_no;
      if (reset) begin
         cfg_enable  = 1'b0;
         cfg_length  = KS_LEN_RESET;
         cfg_align   = 1'b0;
         cfg_offset  = '0;
         cfg_step    = '0;
         slot_pos[0] = 0;
         slot_pos[1] = 0;
         expected_frames.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_frames.size() == 0) begin
               $error("response word with no frame outstanding: frame_out %h applied %b",
                      rsp_mon.frame_out, rsp_mon.applied);
               err_total++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_mon.frame_out !== want.frame_out) begin
                  $error("frame_out: expected %h, actual %h", want.frame_out,
                         rsp_mon.frame_out);
                  err_total++;
               end
               if (rsp_mon.applied !== want.applied) begin
                  $error("applied: expected %b, actual %b", want.applied, rsp_mon.applied);
                  err_total++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ENABLE:    cfg_enable = csr_mon.data[0];
               CSR_KS_LENGTH: cfg_length = csr_mon.data;
               CSR_ALIGN:     cfg_align  = csr_mon.data[0];
               CSR_OFFSET:    cfg_offset = csr_mon.data;
               CSR_STEP:      cfg_step   = csr_mon.data;
               default: ;
            endcase
            if (csr_mon.index <= CSR_STEP) begin
               slot_pos[0] = 0;
               slot_pos[1] = 0;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == 1'b0) begin
               // Byte n lands at bits 8n..8n+7, most significant bit first.
               for (int i = 0; i < BYTE_W; i++) begin
                  bit_no = int'(req_mon.byte_index) * BYTE_W + i;
                  if (bit_no < KS_BITS) ks_bits[bit_no] = req_mon.byte_value[BYTE_W-1-i];
               end
            end else begin
               overlay_frame(req_mon.slot, req_mon.frame_bits, want);
               expected_frames.push_back(want);
            end
         end
      end
      pending_frames <= expected_frames.size();
      mismatch_count <= err_total;
   end

endmodule

FILE: test/testbench.sv
// Top of the keystream frame overlay testbench: clock, reset, stimulus, watchdog, verdict.
// Depends on skfo_pkg, skfo_ifs, the overlay unit and skfo_overlay_checker.
module testbench;
   import skfo_pkg::*;

   // Cycles to let pass after the last result before touching the registers. A load word
   // returns nothing and an applied frame is the longest operation, so this covers both.
   localparam int SETTLE_CYCLES   = 100;
   // Longest run of cycles in which no word moves on any channel before we give up.
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int NUM_PHASES      = 12;
   localparam int WORDS_PER_PHASE = 80;
   localparam int STORE_BYTES     = (KS_MAX_BITS_DEF + BYTE_W - 1) / BYTE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLISTED = 3'd7;
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FRAME = 1'b1;

   logic clock;
   logic reset;
   logic no_idle;
   int   pending_frames;
   int   mismatch_count;
   int   idle_cycles;

   skfo_req_if req_bus ();
   skfo_rsp_if rsp_bus ();
   skfo_csr_if csr_bus ();

   static_keystream_frame_overlay_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   skfo_overlay_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .pending_frames (pending_frames),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls in about a third of the cycles, except during the stretch in
   // which neither side is allowed to idle.
   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 32);
   end

   // The watchdog restarts whenever any channel moves a word.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [FRAME_W-1:0] rand_frame();
      return FRAME_W'({$urandom(), $urandom()});
   endfunction

   // Offers one request word and returns at the edge that accepts it. Valid is left high
   // so that a following word can go out back to back; idling lowers it again.
   task automatic send_word(input logic act, input logic sl, input logic [BIDX_W-1:0] bi,
                            input logic [BYTE_W-1:0] bv, input logic [FRAME_W-1:0] fb);
      while (!no_idle && $urandom_range(0, 99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.slot       <= sl;
      req_bus.byte_index <= bi;
      req_bus.byte_value <= bv;
      req_bus.frame_bits <= fb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Frame words carry random filler in the byte fields, so those bits toggle too.
   task automatic send_frame(input logic sl, input logic [FRAME_W-1:0] fb);
      send_word(ACT_FRAME, sl, BIDX_W'($urandom()), BYTE_W'($urandom()), fb);
   endtask

   task automatic send_load(input logic [BIDX_W-1:0] bi, input logic [BYTE_W-1:0] bv);
      send_word(ACT_LOAD, 1'($urandom()), bi, bv, rand_frame());
   endtask

   // Stops sending and waits until every frame has been answered and the block is quiet.
   // The first edge lets the checker count a word accepted at this very edge.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reprograms every register once the block has gone quiet.
   task automatic program_overlay(input logic en, input logic [LEN_W-1:0] len,
                                  input logic al, input logic [LEN_W-1:0] off,
                                  input logic [LEN_W-1:0] st);
      drain();
      write_reg(CSR_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_KS_LENGTH, len);
      write_reg(CSR_ALIGN, CSR_DATA_W'(al));
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_STEP, st);
   endtask

   initial begin
      logic [FRAME_W-1:0] quiet;
      logic [LEN_W-1:0]   len;
      logic [LEN_W-1:0]   off;
      logic [LEN_W-1:0]   st;
      int                 pick;
      int                 hold_at;

      // Every block input is known from time zero, while reset is held high at the start.
      reset              = 1'b1;
      no_idle            = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_LOAD;
      req_bus.slot       = 1'b0;
      req_bus.byte_index = '0;
      req_bus.byte_value = '0;
      req_bus.frame_bits = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_ENABLE;
      csr_bus.data       = '0;
      rsp_bus.ready      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      quiet = silence_frame();

      // Fill the whole keystream first, so no frame ever reads a bit that was never
      // written. The last byte only partly fits; two loads fall wholly past the store.
      for (int b = 0; b < STORE_BYTES; b++) begin
         send_load(BIDX_W'(b), BYTE_W'($urandom()));
      end
      send_load(BIDX_W'(STORE_BYTES), 8'hFF);
      send_load('1, 8'hFF);

      // Out of reset the overlay is off, so a frame comes back untouched.
      send_frame(1'b0, '1);

      // Plain mode over the full length: extremes of the frame, both slots, the silence
      // pattern, a near-silence frame and a frame whose tail bits are all zero.
      program_overlay(1'b1, LEN_W'(KS_MAX_BITS_DEF), 1'b0, '0, '0);
      send_frame(1'b0, '1);
      send_frame(1'b0, '1);
      send_frame(1'b1, '0);
      send_frame(1'b1, quiet);
      send_frame(1'b1, quiet ^ FRAME_W'(1));
      send_frame(1'b1, ~(FRAME_W'(20'hFFFFF) << TAIL_LO));
      send_frame(1'b0, rand_frame());

      // A one-bit keystream with offset and step far beyond it.
      program_overlay(1'b1, LEN_W'(1), 1'b1, LEN_W'(881), LEN_W'(881));
      send_frame(1'b0, rand_frame());
      send_frame(1'b0, '1);

      // Zero length behaves like a disabled overlay.
      program_overlay(1'b1, '0, 1'b0, '0, '0);
      send_frame(1'b1, '1);

      // A length above the store is clipped, and offset and step wrap at it.
      program_overlay(1'b1, '1, 1'b1, '1, '1);
      send_frame(1'b0, rand_frame());
      send_frame(1'b0, rand_frame());
      send_frame(1'b1, rand_frame());

      // A short length in aligned mode, so the 49-bit walk wraps within one frame.
      program_overlay(1'b1, LEN_W'(50), 1'b1, LEN_W'(49), LEN_W'(881));
      send_frame(1'b0, rand_frame());
      send_frame(1'b0, rand_frame());
      send_frame(1'b0, rand_frame());

      // A write to an unlisted register leaves the positions where they are.
      drain();
      write_reg(CSR_UNLISTED, '1);
      send_frame(1'b0, rand_frame());

      // Random phases, each with its own register settings. The fifth phase runs with
      // no idling on either side, and every phase pauses once until all results are in.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       len = LEN_W'(1);
            1:       len = LEN_W'(KS_MAX_BITS_DEF);
            2:       len = '0;
            3:       len = LEN_W'($urandom_range(KS_MAX_BITS_DEF + 1, 1023));
            4:       len = LEN_W'($urandom_range(FRAME_W - 1, FRAME_W + 1));
            default: len = LEN_W'($urandom_range(1, KS_MAX_BITS_DEF));
         endcase
         off = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom()) :
                                             LEN_W'($urandom_range(0, 881));
         st  = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom()) :
                                             LEN_W'($urandom_range(0, 881));
         program_overlay($urandom_range(0, 9) != 0, len, 1'($urandom()), off, st);
         no_idle = (ph == 4);
         hold_at = $urandom_range(10, WORDS_PER_PHASE - 10);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == hold_at) drain();
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               send_load(BIDX_W'($urandom()), BYTE_W'($urandom()));
            end else if (pick < 28) begin
               send_frame(1'($urandom()), quiet);
            end else if (pick < 34) begin
               send_frame(1'($urandom()), quiet ^ (FRAME_W'(1) << $urandom_range(0, 48)));
            end else if (pick < 44) begin
               send_frame(1'($urandom()), rand_frame() & ~(FRAME_W'(20'hFFFFF) << TAIL_LO));
            end else begin
               send_frame(1'($urandom()), rand_frame());
            end
         end
         no_idle = 1'b0;
      end

      // Let the last results come home, then give the verdict.
      drain();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
